// ===== rtl/sst_pkg.sv =====
// shared types, constants and helper functions of the source tokenizer
package sst_pkg;

    localparam int POSITION_BITS = 16;
    localparam int HEAD_CHARS    = 5;
    localparam int HEAD_IDX_BITS = $clog2(HEAD_CHARS);
    localparam int LEN_BITS      = 16;
    localparam int KW_BYTES      = 5;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

    typedef logic [POSITION_BITS-1:0] pos_t;
    typedef logic [LEN_BITS-1:0]      len_t;

    typedef enum logic [3:0] {
        KIND_LPAREN       = 4'd0,
        KIND_LBRACE       = 4'd1,
        KIND_RPAREN       = 4'd2,
        KIND_RBRACE       = 4'd3,
        KIND_ASSIGN       = 4'd4,
        KIND_OPERATOR     = 4'd5,
        KIND_LET          = 4'd6,
        KIND_DEF          = 4'd7,
        KIND_BOOL         = 4'd8,
        KIND_NUMBER       = 4'd9,
        KIND_IDENT        = 4'd10,
        KIND_UNRECOGNISED = 4'd11
    } kind_t;

    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;
    localparam logic [7:0] CH_PLUS   = 8'h2b;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_STAR   = 8'h2a;

    localparam len_t LEN_MAX = '1;

    // keywords, first character in the lowest byte
    localparam logic [KW_BYTES-1:0][7:0] KW_ASSIGN = {8'h00, 8'h00, 8'h00, 8'h00, "="};
    localparam logic [KW_BYTES-1:0][7:0] KW_LET    = {8'h00, 8'h00, "t", "e", "l"};
    localparam logic [KW_BYTES-1:0][7:0] KW_DEF    = {8'h00, 8'h00, "f", "e", "d"};
    localparam logic [KW_BYTES-1:0][7:0] KW_TRUE   = {8'h00, "e", "u", "r", "T"};
    localparam logic [KW_BYTES-1:0][7:0] KW_FALSE  = {"e", "s", "l", "a", "F"};

    typedef struct packed {
        len_t                        len;
        logic                        all_digits;
        logic                        all_letters;
        logic [HEAD_CHARS-1:0][7:0]  head;
        pos_t                        start;
    } word_t;

    localparam word_t WORD_CLEAR = '{
        len:         '0,
        all_digits:  1'b1,
        all_letters: 1'b1,
        head:        '0,
        start:       '0
    };

    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  symbol;
        logic [15:0] token_length;
        logic [15:0] start_pos;
        logic        last_of_run;
    } token_t;

    typedef struct packed {
        logic [1:0]        n;
        token_t [1:0]      toks;
    } push_t;

    function automatic logic is_space(logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_punct(logic [7:0] c);
        return (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_LBRACE) ||
               (c == CH_RBRACE) || (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR);
    endfunction

    function automatic kind_t punct_kind(logic [7:0] c);
        kind_t k;
        unique case (c)
            CH_LPAREN: k = KIND_LPAREN;
            CH_LBRACE: k = KIND_LBRACE;
            CH_RPAREN: k = KIND_RPAREN;
            CH_RBRACE: k = KIND_RBRACE;
            default:   k = KIND_OPERATOR;
        endcase
        return k;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_letter(logic [7:0] c);
        return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
    endfunction

    function automatic logic word_is(word_t w, logic [KW_BYTES-1:0][7:0] kw, int klen);
        logic ok;
        ok = (w.len == len_t'(klen));
        for (int i = 0; i < KW_BYTES; i++) begin
            if ((i < klen) && (w.head[i] != kw[i])) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    function automatic kind_t classify(word_t w);
        kind_t k;
        if (word_is(w, KW_ASSIGN, 1)) begin
            k = KIND_ASSIGN;
        end
        else if (word_is(w, KW_LET, 3)) begin
            k = KIND_LET;
        end
        else if (word_is(w, KW_DEF, 3)) begin
            k = KIND_DEF;
        end
        else if (word_is(w, KW_TRUE, 4) || word_is(w, KW_FALSE, 5)) begin
            k = KIND_BOOL;
        end
        else if (w.all_digits) begin
            k = KIND_NUMBER;
        end
        else if (w.all_letters) begin
            k = KIND_IDENT;
        end
        else begin
            k = KIND_UNRECOGNISED;
        end
        return k;
    endfunction

    function automatic token_t make_token(kind_t k, logic [7:0] s, len_t l, pos_t p);
        token_t t;
        t.kind         = k;
        t.symbol       = s;
        t.token_length = 16'(l);
        t.start_pos    = 16'(p);
        t.last_of_run  = 1'b0;
        return t;
    endfunction

endpackage

// ===== rtl/sst_char_if.sv =====
// character input channel of the source tokenizer
interface sst_char_if
    import sst_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_of_text;

    modport source (output valid, output ch, output end_of_text, input ready);
    modport sink (input valid, input ch, input end_of_text, output ready);
endinterface

// ===== rtl/sst_token_if.sv =====
// token output channel of the source tokenizer
interface sst_token_if
    import sst_pkg::*;
();
    logic        valid;
    logic        ready;
    logic [3:0]  kind;
    logic [7:0]  symbol;
    logic [15:0] token_length;
    logic [15:0] start_pos;
    logic        last_of_run;

    modport source (output valid, output kind, output symbol, output token_length,
                    output start_pos, output last_of_run, input ready);
    modport sink (input valid, input kind, input symbol, input token_length,
                  input start_pos, input last_of_run, output ready);
endinterface

// ===== rtl/sst_lexer.sv =====
// lexer state and per-character token logic
module sst_lexer
    import sst_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [7:0] ch,
    input  logic       end_of_text,
    output push_t      push
);

    logic  comment_reg, comment_next;
    logic  slash_reg, slash_next;
    word_t word_reg, word_next;
    pos_t  pos_reg, pos_next;
    logic  do_handle;
    logic  [1:0] n;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comment_reg <= 1'b0;
            slash_reg   <= 1'b0;
            word_reg    <= WORD_CLEAR;
            pos_reg     <= '0;
        end
        else
        begin
            comment_reg <= comment_next;
            slash_reg   <= slash_next;
            word_reg    <= word_next;
            pos_reg     <= pos_next;
        end
    end

    always_comb
    begin
        comment_next = comment_reg;
        slash_next   = slash_reg;
        word_next    = word_reg;
        pos_next     = pos_reg;
        do_handle    = 1'b0;
        n            = 2'd0;
        push.toks    = '0;
        if (fire)
        begin
            if (comment_reg)
            begin
                if (ch == CH_LF)
                begin
                    comment_next = 1'b0;
                end
            end
            else if (slash_reg)
            begin
                slash_next = 1'b0;
                if (ch == CH_SLASH)
                begin
                    comment_next = 1'b1;
                end
                else
                begin
                    push.toks[n[0]] = make_token(KIND_OPERATOR, CH_SLASH, len_t'(1),
                                                 pos_reg - pos_t'(1));
                    n = n + 2'd1;
                    do_handle = 1'b1;
                end
            end
            else
            begin
                do_handle = 1'b1;
            end

            if (do_handle)
            begin
                if (is_space(ch) || is_punct(ch) || (ch == CH_SLASH))
                begin
                    if (word_next.len != '0)
                    begin
                        push.toks[n[0]] = make_token(classify(word_next), word_next.head[0],
                                                     word_next.len, word_next.start);
                        n = n + 2'd1;
                        word_next = WORD_CLEAR;
                    end
                    if (is_punct(ch))
                    begin
                        push.toks[n[0]] = make_token(punct_kind(ch), ch, len_t'(1), pos_reg);
                        n = n + 2'd1;
                    end
                    if (ch == CH_SLASH)
                    begin
                        slash_next = 1'b1;
                    end
                end
                else
                begin
                    if (word_next.len == '0)
                    begin
                        word_next.start = pos_reg;
                    end
                    if (word_next.len < len_t'(HEAD_CHARS))
                    begin
                        word_next.head[word_next.len[HEAD_IDX_BITS-1:0]] = ch;
                    end
                    if (word_next.len != LEN_MAX)
                    begin
                        word_next.len = word_next.len + len_t'(1);
                    end
                    if (!is_digit(ch))
                    begin
                        word_next.all_digits = 1'b0;
                    end
                    if (!is_letter(ch))
                    begin
                        word_next.all_letters = 1'b0;
                    end
                end
            end

            pos_next = pos_reg + pos_t'(1);

            if (end_of_text)
            begin
                if (slash_next)
                begin
                    push.toks[n[0]] = make_token(KIND_OPERATOR, CH_SLASH, len_t'(1), pos_reg);
                    n = n + 2'd1;
                end
                if (word_next.len != '0)
                begin
                    push.toks[n[0]] = make_token(classify(word_next), word_next.head[0],
                                                 word_next.len, word_next.start);
                    n = n + 2'd1;
                end
                comment_next = 1'b0;
                slash_next   = 1'b0;
                word_next    = WORD_CLEAR;
                pos_next     = '0;
            end

            if (n != 2'd0)
            begin
                push.toks[n[1]].last_of_run = 1'b1;
            end
        end
        push.n = n;
    end

endmodule

// ===== rtl/sst_out_queue.sv =====
// small token queue taking up to two tokens a cycle and giving one
module sst_out_queue
    import sst_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  push_t         push,
    output logic          room,
    sst_token_if.source   tok
);

    token_t                    entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_BITS:0]   count_reg, count_next;
    logic                      pop;
    token_t                    head;

    assign pop  = tok.valid && tok.ready;
    assign room = (count_reg <= (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QUEUE_PTR_BITS'(push.n);
        rd_ptr_next = rd_ptr_reg + QUEUE_PTR_BITS'(pop);
        count_next  = count_reg + (QUEUE_PTR_BITS+1)'(push.n) - (QUEUE_PTR_BITS+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.toks[0];
        end
        if (push.n == 2'd2)
        begin
            entry_reg[wr_ptr_reg + QUEUE_PTR_BITS'(1)] <= push.toks[1];
        end
    end

    assign head             = entry_reg[rd_ptr_reg];
    assign tok.valid        = (count_reg != '0);
    assign tok.kind         = head.kind;
    assign tok.symbol       = head.symbol;
    assign tok.token_length = head.token_length;
    assign tok.start_pos    = head.start_pos;
    assign tok.last_of_run  = head.last_of_run;

endmodule

// ===== rtl/streaming_source_tokenizer_core.sv =====
// top level of the streaming source tokenizer
// Takes one source character per cycle while the output queue has room and gives classified
// tokens: brackets, operators, '=', let, def, booleans, numbers, identifiers and unrecognised
// words, with "//" comments skipped up to the newline. A character is registered on acceptance,
// worked through the lexer once the queue has room and its tokens, none, one or two, enter a
// four-word output queue; the first token is offered once it has been written from the input
// register through the lexer into a queue entry. The input keeps taking a character every
// cycle while the queue has room for two tokens, so it can accept a new character before the
// tokens of the last one have left the queue; the queue's single read port gives at most one
// token a cycle while the receiver is ready. The last token of each character carries
// last_of_run, and end_of_text flushes the pending word and slash, then clears all state.
module streaming_source_tokenizer_core
    import sst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    sst_char_if.sink    src,
    sst_token_if.source tok
);

    logic       in_valid_reg;
    logic [7:0] ch_reg;
    logic       eot_reg;
    logic       room;
    logic       fire;
    push_t      push;

    assign fire      = in_valid_reg && room;
    assign src.ready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (src.ready)
        begin
            in_valid_reg <= src.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src.valid && src.ready)
        begin
            ch_reg  <= src.ch;
            eot_reg <= src.end_of_text;
        end
    end

    sst_lexer u_lexer (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .ch          (ch_reg),
        .end_of_text (eot_reg),
        .push        (push)
    );

    sst_out_queue u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .room  (room),
        .tok   (tok)
    );

`ifndef NO_ASSERTIONS
    a_push_from_item: assert property (@(posedge clk) disable iff (!rst_n)
        push.n != 2'd0 |-> fire)
        else $error("tokens pushed without a character");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        push.n != 2'd3)
        else $error("more than two tokens from one character");

    a_last_marks: assert property (@(posedge clk) disable iff (!rst_n)
        push.n == 2'd2 |-> (!push.toks[0].last_of_run && push.toks[1].last_of_run))
        else $error("last_of_run on the wrong token of a pair");

    a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
        push.n != 2'd0 |=> tok.valid)
        else $error("pushed token not offered on the output");
`endif

endmodule
